[design/cadss_pkg.sv]
// ============================================================================
// cadss_pkg: shared types and constants of the C-alpha distance labeller
// Field widths, target distances, label and register codes, and the record
// that passes from the front end to the back end.
// ============================================================================
package cadss_pkg;

    localparam int COORD_W    = 20;
    localparam int IDX_W      = 12;
    localparam int TOL_W      = 10;
    localparam int WLEN_W     = 5;
    localparam int LBL_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;
    localparam int DIFF_W     = 16;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DSQ_W      = SQ_W + 2;
    localparam int TGT_W      = 12;
    localparam int HI_W       = TGT_W + 1;
    localparam int HISQ_W     = 2 * HI_W;
    localparam int LOSQ_W     = 2 * TGT_W;
    localparam int NUM_TGT    = 6;
    localparam int NSLOT      = 5;
    localparam int SLOT_W     = 3;
    localparam int FILL_W     = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    // Structure labels
    localparam logic [LBL_W-1:0] LBL_COIL   = 2'd0;
    localparam logic [LBL_W-1:0] LBL_HELIX  = 2'd1;
    localparam logic [LBL_W-1:0] LBL_STRAND = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_STRAND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HELIX_TOL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAND_TOL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HELIX_WLEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAND_WLEN = 3'd4;

    localparam logic [TOL_W-1:0]  HELIX_TOL_RST  = 10'd538;
    localparam logic [TOL_W-1:0]  STRAND_TOL_RST = 10'd410;
    localparam logic [WLEN_W-1:0] WLEN_RST       = 5'd5;

    // Target distances in Q8 angstroms: three helix targets, then three strand
    // targets, for residue spacings of two, three and four.
    localparam logic [TGT_W-1:0] TARGET [NUM_TGT] = '{
        12'd1395, 12'd1326, 12'd1631,
        12'd1562, 12'd2662, 12'd3328
    };

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic              coil_strand;
        logic [TOL_W-1:0]  helix_tol;
        logic [TOL_W-1:0]  strand_tol;
        logic [WLEN_W-1:0] helix_wlen;
        logic [WLEN_W-1:0] strand_wlen;
    } cfg_t;

    // One accepted residue's worth of final labels: slots first_slot up to 0,
    // or up to 4 when the residue closes the chain.
    typedef struct packed {
        logic [IDX_W-1:0]             base;
        logic [SLOT_W-1:0]            first_slot;
        logic                         last;
        logic [NSLOT-1:0][LBL_W-1:0]  lab;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Absolute difference of two coordinates, clamped to the squarer's width.
    function automatic logic [DIFF_W-1:0] absdiff_clamp(coord_t a, coord_t b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        ad;
        d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        ad = d[COORD_W] ? (~d + 1'b1) : d;
        return (|ad[COORD_W:DIFF_W]) ? {DIFF_W{1'b1}} : ad[DIFF_W-1:0];
    endfunction

endpackage

[design/cadss_front.sv]
// ============================================================================
// cadss_front: distance pipeline and label assignment
// Accepts residues, measures squared distances over a five-residue window,
// tests them against the helix and strand bands and decides final labels.
// ============================================================================
module cadss_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cadss_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    input  cadss_pkg::cfg_t                     cfg,
    input  logic                                q_full,
    output cadss_pkg::push_t                    push
);

    logic adv;
    logic accept;

    cadss_pkg::coord_t in_c [3];
    cadss_pkg::coord_t win_reg [4][3];

    logic [cadss_pkg::DIFF_W-1:0] diff_reg [3][3];
    logic [cadss_pkg::SQ_W-1:0]   sq_reg [3][3];
    logic                         s1_valid_reg, s1_last_reg, s1_coil_reg;
    logic                         s2_valid_reg, s2_last_reg, s2_coil_reg;

    logic [cadss_pkg::TOL_W-1:0]  tol [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::HI_W-1:0]   hsum [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::TGT_W-1:0]  ldif [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::HISQ_W-1:0] hisq_next [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::LOSQ_W-1:0] losq_next [cadss_pkg::NUM_TGT];
    logic                         loen_next [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::HISQ_W-1:0] hisq_reg [cadss_pkg::NUM_TGT];
    logic [cadss_pkg::LOSQ_W-1:0] losq_reg [cadss_pkg::NUM_TGT];
    logic                         loen_reg [cadss_pkg::NUM_TGT];

    logic [cadss_pkg::DSQ_W-1:0]  dsq [3];
    logic [cadss_pkg::NUM_TGT-1:0] pass;
    logic                         hpass, spass, hcenter, scenter;
    logic                         full4, full5, has_rec;

    logic [cadss_pkg::FILL_W-1:0] fill_reg;
    logic [cadss_pkg::IDX_W-1:0]  cnt_reg;
    logic [1:0]                   hhist_reg, shist_reg;
    logic [3:0][cadss_pkg::LBL_W-1:0] pend_reg;
    logic [cadss_pkg::NSLOT-1:0][cadss_pkg::LBL_W-1:0] lab;

    // The whole pipeline holds while a finished residue cannot enter the queue.
    assign adv      = !(s2_valid_reg && q_full);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign in_c[0] = s_tdata[cadss_pkg::COORD_W-1:0];
    assign in_c[1] = s_tdata[2*cadss_pkg::COORD_W-1:cadss_pkg::COORD_W];
    assign in_c[2] = s_tdata[3*cadss_pkg::COORD_W-1:2*cadss_pkg::COORD_W];

    // Band limits follow the tolerance registers in the next cycle (registered).
    always_comb begin
        for (int j = 0; j < cadss_pkg::NUM_TGT; j++) begin
            tol[j]       = (j < 3) ? cfg.helix_tol : cfg.strand_tol;
            hsum[j]      = {1'b0, cadss_pkg::TARGET[j]} + {3'b0, tol[j]};
            ldif[j]      = cadss_pkg::TARGET[j] - {2'b0, tol[j]};
            loen_next[j] = cadss_pkg::TARGET[j] > {2'b0, tol[j]};
            hisq_next[j] = {{cadss_pkg::HI_W{1'b0}}, hsum[j]}
                         * {{cadss_pkg::HI_W{1'b0}}, hsum[j]};
            losq_next[j] = {{cadss_pkg::TGT_W{1'b0}}, ldif[j]}
                         * {{cadss_pkg::TGT_W{1'b0}}, ldif[j]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < cadss_pkg::NUM_TGT; j++) begin
            hisq_reg[j] <= hisq_next[j];
            losq_reg[j] <= losq_next[j];
            loen_reg[j] <= loen_next[j];
        end
    end

    // Stage 1: differences from the oldest residue to those two, three and
    // four places ahead; stage 2: their squares.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int a = 0; a < 3; a++) begin
                diff_reg[0][a] <= cadss_pkg::absdiff_clamp(win_reg[0][a], win_reg[2][a]);
                diff_reg[1][a] <= cadss_pkg::absdiff_clamp(win_reg[0][a], win_reg[3][a]);
                diff_reg[2][a] <= cadss_pkg::absdiff_clamp(win_reg[0][a], in_c[a]);
                win_reg[0][a]  <= win_reg[1][a];
                win_reg[1][a]  <= win_reg[2][a];
                win_reg[2][a]  <= win_reg[3][a];
                win_reg[3][a]  <= in_c[a];
            end
            s1_last_reg <= s_tlast;
            s1_coil_reg <= cfg.coil_strand;
        end
        if (adv) begin
            for (int d = 0; d < 3; d++) begin
                for (int a = 0; a < 3; a++) begin
                    sq_reg[d][a] <= {{cadss_pkg::DIFF_W{1'b0}}, diff_reg[d][a]}
                                  * {{cadss_pkg::DIFF_W{1'b0}}, diff_reg[d][a]};
                end
            end
            s2_last_reg <= s1_last_reg;
            s2_coil_reg <= s1_coil_reg;
        end
    end

    // Stage 3: band tests, centre detection and label overwrite.
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            dsq[d] = {2'b0, sq_reg[d][0]} + {2'b0, sq_reg[d][1]} + {2'b0, sq_reg[d][2]};
        end
        for (int k = 0; k < 2; k++) begin
            for (int d = 0; d < 3; d++) begin
                pass[k*3+d] = (!loen_reg[k*3+d]
                               || dsq[d] >= {10'b0, losq_reg[k*3+d]})
                              && dsq[d] <= {8'b0, hisq_reg[k*3+d]};
            end
        end
        hpass   = &pass[2:0];
        spass   = &pass[5:3];
        full4   = fill_reg >= 3'd4;
        full5   = fill_reg >= 3'd5;
        hcenter = full5 && hhist_reg[1] && hpass;
        scenter = full5 && shist_reg[1] && spass;

        lab[3:0] = pend_reg;
        lab[4]   = s2_coil_reg ? cadss_pkg::LBL_STRAND : cadss_pkg::LBL_COIL;
        if (hcenter) begin
            lab[0] = cadss_pkg::LBL_HELIX;
            lab[1] = cadss_pkg::LBL_HELIX;
            lab[2] = cadss_pkg::LBL_HELIX;
        end
        if (scenter) begin
            lab[0] = cadss_pkg::LBL_STRAND;
            lab[1] = cadss_pkg::LBL_STRAND;
            lab[2] = cadss_pkg::LBL_STRAND;
        end

        has_rec                = full4 || s2_last_reg;
        push.valid             = s2_valid_reg && adv && has_rec;
        push.entry.base        = cnt_reg - 12'd4;
        push.entry.first_slot  = full4 ? 3'd0 : 3'd4 - fill_reg;
        push.entry.last        = s2_last_reg;
        push.entry.lab         = lab;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            hhist_reg    <= '0;
            shist_reg    <= '0;
            pend_reg     <= '0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg) begin
                if (s2_last_reg) begin
                    fill_reg  <= '0;
                    cnt_reg   <= '0;
                    hhist_reg <= '0;
                    shist_reg <= '0;
                    pend_reg  <= '0;
                end else begin
                    pend_reg <= lab[4:1];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (!full5) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    if (full4) begin
                        hhist_reg <= {hpass, hhist_reg[1]};
                        shist_reg <= {spass, shist_reg[1]};
                    end
                end
            end
        end
    end

endmodule

[design/cadss_back.sv]
// ============================================================================
// cadss_back: label queue, window tracking and result register
// Buffers label records per residue, gives one result per cycle while the
// receiver is ready; reports fixed-length windows ending in equal-label runs.
// ============================================================================
module cadss_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cadss_pkg::push_t                push,
    output logic                            q_full,
    input  cadss_pkg::cfg_t                 cfg,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cadss_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    cadss_pkg::entry_t q_mem [cadss_pkg::QDEPTH];
    logic [cadss_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cadss_pkg::QCNT_W-1:0] cnt_reg;

    cadss_pkg::entry_t            work_reg;
    logic [cadss_pkg::SLOT_W-1:0] slot_reg;
    logic                         busy_reg;

    logic                         m_valid_reg, m_last_reg;
    logic [cadss_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [cadss_pkg::LBL_W-1:0]  run_type_reg;
    logic [cadss_pkg::IDX_W-1:0]  run_len_reg;

    logic                         out_free, emit, done, pop;
    logic [cadss_pkg::SLOT_W-1:0] hi_slot;
    logic [cadss_pkg::IDX_W-1:0]  rec_idx, len_next, win_start;
    logic [cadss_pkg::LBL_W-1:0]  rec_lbl, type_next, win_type;
    logic                         rec_last, is_run, win_valid;
    logic [cadss_pkg::WLEN_W-1:0] wlen, wlen_eff;

    assign q_full   = cnt_reg == cadss_pkg::QCNT_W'(cadss_pkg::QDEPTH);
    assign out_free = !m_valid_reg || m_tready;
    assign hi_slot  = work_reg.last ? 3'd4 : 3'd0;
    assign emit     = busy_reg && out_free;
    assign done     = emit && (slot_reg == hi_slot);
    assign pop      = (cnt_reg != '0) && (!busy_reg || done);

    always_comb begin
        rec_idx  = work_reg.base + {9'b0, slot_reg};
        rec_lbl  = work_reg.lab[slot_reg];
        rec_last = work_reg.last && (slot_reg == 3'd4);
        is_run   = (rec_lbl == cadss_pkg::LBL_HELIX) || (rec_lbl == cadss_pkg::LBL_STRAND);
        wlen     = (rec_lbl == cadss_pkg::LBL_HELIX) ? cfg.helix_wlen : cfg.strand_wlen;
        wlen_eff = (wlen == '0) ? 5'd1 : wlen;

        if (!is_run) begin
            type_next = cadss_pkg::LBL_COIL;
            len_next  = '0;
        end else if (run_type_reg == rec_lbl) begin
            type_next = rec_lbl;
            len_next  = (&run_len_reg) ? run_len_reg : run_len_reg + 1'b1;
        end else begin
            type_next = rec_lbl;
            len_next  = 12'd1;
        end

        win_valid = is_run && (len_next >= {7'b0, wlen_eff});
        win_start = win_valid ? rec_idx - {7'b0, wlen_eff} + 1'b1 : '0;
        win_type  = win_valid ? rec_lbl : cadss_pkg::LBL_COIL;
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            q_mem[wr_ptr_reg] <= push.entry;
        end
        if (pop) begin
            work_reg <= q_mem[rd_ptr_reg];
        end
        if (emit) begin
            m_data_reg <= {3'b0, win_type, win_start, win_valid, rec_lbl, rec_idx};
            m_last_reg <= rec_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            slot_reg     <= '0;
            m_valid_reg  <= 1'b0;
            run_type_reg <= cadss_pkg::LBL_COIL;
            run_len_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {2'b0, push.valid} - {2'b0, pop};

            if (pop) begin
                busy_reg <= 1'b1;
                slot_reg <= q_mem[rd_ptr_reg].first_slot;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                slot_reg <= slot_reg + 1'b1;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
                // The run is forgotten once a chain has been flushed.
                if (rec_last) begin
                    run_type_reg <= cadss_pkg::LBL_COIL;
                    run_len_reg  <= '0;
                end else begin
                    run_type_reg <= type_next;
                    run_len_reg  <= len_next;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !q_full)
        else $error("label record pushed into a full queue");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> slot_reg <= 3'd4 && slot_reg >= work_reg.first_slot)
        else $error("slot outside the record's range");

    a_run_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_type_reg == cadss_pkg::LBL_COIL) == (run_len_reg == '0))
        else $error("run type and run length disagree");

    a_window_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[14] |->
            m_data_reg[28:27] == m_data_reg[13:12]
            && m_data_reg[13:12] != cadss_pkg::LBL_COIL)
        else $error("window type does not match its residue label");

    a_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && rec_last |=> run_len_reg == '0)
        else $error("run not cleared after the end of a chain");
`endif

endmodule

[design/ca_distance_secondary_structure.sv]
// ============================================================================
// ca_distance_secondary_structure: C-alpha distance secondary structure labeller
// Labels each residue coil, helix or strand from its C-alpha distances and
// reports fixed-length windows inside runs of equal labels.
// ============================================================================
// Use:
//   The input channel takes one residue per item: x, y and z in tdata and the
//   end-of-chain mark in tlast. The result channel gives one item per labelled
//   residue; tlast marks the final result of a chain.
//   A residue's label is final once four more residues have arrived, so in
//   mid-chain each item produces the result of the residue four places back.
//   The chain's last item flushes the pending residues, up to five results.
//   The input takes one item per cycle while tready is high; results leave
//   at one per cycle while the receiver accepts them. A result passes through
//   the three-stage distance pipeline, the queue and the output register.
//   A four-entry queue separates the distance pipeline from the result stage;
//   when the receiver stalls, the queue fills and tready falls only once it is
//   full, and nothing is lost.
//   Configuration registers are written via cfg_we, cfg_index and cfg_wdata,
//   by the user only while no chain is in flight; the block does not check.
//   Synchronous reset clears all chain state, restores the register defaults.
// ============================================================================
module ca_distance_secondary_structure (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_coord [19:0], y_coord [39:20], z_coord [59:40], zero fill [63:60]
    input  logic [cadss_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // residue_index [11:0], structure_label [13:12], window_valid [14],
    // window_start [26:15], window_type [28:27], zero fill [31:29]
    output logic [cadss_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cadss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cadss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    cadss_pkg::cfg_t  cfg_reg;
    cadss_pkg::push_t push;
    logic             q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coil_strand <= 1'b0;
            cfg_reg.helix_tol   <= cadss_pkg::HELIX_TOL_RST;
            cfg_reg.strand_tol  <= cadss_pkg::STRAND_TOL_RST;
            cfg_reg.helix_wlen  <= cadss_pkg::WLEN_RST;
            cfg_reg.strand_wlen <= cadss_pkg::WLEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cadss_pkg::CFG_COIL_STRAND: cfg_reg.coil_strand <= cfg_wdata[0];
                cadss_pkg::CFG_HELIX_TOL:   cfg_reg.helix_tol   <= cfg_wdata;
                cadss_pkg::CFG_STRAND_TOL:  cfg_reg.strand_tol  <= cfg_wdata;
                cadss_pkg::CFG_HELIX_WLEN:  cfg_reg.helix_wlen  <= cfg_wdata[4:0];
                cadss_pkg::CFG_STRAND_WLEN: cfg_reg.strand_wlen <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    cadss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push)
    );

    cadss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_full   (q_full),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
